// ----- hw/rtl/longest_match_symbol_sum_unit_assert.svh -----
// Assertion macros used by the longest-match symbol sum top level.
`ifndef LONGEST_MATCH_SYMBOL_SUM_UNIT_ASSERT_SVH
`define LONGEST_MATCH_SYMBOL_SUM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lmss_pkg.sv -----
// Package: sizes, entry layout, function codes and helpers for the symbol sum unit.
package lmss_pkg;

  localparam int ENTRIES        = 16;
  localparam int MAX_SYMBOL_LEN = 4;
  localparam int LOOKAHEAD      = (MAX_SYMBOL_LEN < 4) ? MAX_SYMBOL_LEN : 4;

  localparam int SYM_W   = 32;
  localparam int REQ_W   = 3;
  localparam int VAL_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int LEN_W   = $clog2(LOOKAHEAD + 1);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PEND_W  = BYTE_W * LOOKAHEAD;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_PARSE  = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [SYM_W-1:0]        sym;
    logic [LEN_W-1:0]        len;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the best-match tracker
  typedef struct packed {
    logic clr;
    logic eval;
  } best_ctl_t;

  // Effective length: request saturated to the lookahead, cut at the first zero byte
  function automatic logic [LEN_W-1:0] eff_len(input logic [SYM_W-1:0] sym,
                                               input logic [REQ_W-1:0] req);
    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] n;
    logic             run;
    lim = (req > REQ_W'(LOOKAHEAD)) ? LEN_W'(LOOKAHEAD) : LEN_W'(req);
    n   = '0;
    run = 1'b1;
    for (int b = 0; b < LOOKAHEAD; b++) begin
      if (run && (LEN_W'(b) < lim) && (sym[BYTE_W*b +: BYTE_W] != '0)) begin
        n = n + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/lmss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lmss_best.sv -----
// Best-match tracker: compares one table entry per cycle against the pending bytes.
module lmss_best (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lmss_pkg::best_ctl_t             ctl_i,
  input  lmss_pkg::entry_t                ent_i,
  input  logic [lmss_pkg::PEND_W-1:0]     pend_i,
  input  logic [lmss_pkg::LEN_W-1:0]      fill_i,
  output logic [lmss_pkg::LEN_W-1:0]      match_len_o,
  output logic signed [lmss_pkg::VAL_W-1:0] best_val_o
);
  import lmss_pkg::*;

  logic [LEN_W-1:0]        match_len_q, match_len_d;
  logic signed [VAL_W-1:0] best_val_q, best_val_d;
  logic                    hit;

  // Masked byte compare over the entry's effective length
  always_comb begin
    hit = (ent_i.len != '0) && (ent_i.len <= fill_i) && (ent_i.len > match_len_q);
    for (int b = 0; b < LOOKAHEAD; b++) begin
      if ((LEN_W'(b) < ent_i.len) &&
          (pend_i[BYTE_W*b +: BYTE_W] != ent_i.sym[BYTE_W*b +: BYTE_W])) begin
        hit = 1'b0;
      end
    end
  end

  // Strictly longer wins, so the earliest entry keeps a tie
  always_comb begin
    match_len_d = match_len_q;
    best_val_d  = best_val_q;
    if (ctl_i.clr) begin
      match_len_d = '0;
      best_val_d  = '0;
    end else if (ctl_i.eval && hit) begin
      match_len_d = ent_i.len;
      best_val_d  = ent_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_len_q <= '0;
      best_val_q  <= '0;
    end else begin
      match_len_q <= match_len_d;
      best_val_q  <= best_val_d;
    end
  end

  assign match_len_o = match_len_q;
  assign best_val_o  = best_val_q;

endmodule

// ----- hw/rtl/longest_match_symbol_sum_unit.sv -----
// Top level: greedy longest-match tokenizer summing symbol values from a RAM table.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | func, entry_symbol/length/value, text/last
//  out     | output    | out_valid_o/out_ready_i | total, stopped_early, table_full
//
// Append and clear items are handled in idle; a parse byte also passes through the check state when no decision is due.
// Each match decision scans the table RAM one entry per cycle, and a full buffer or
// end-of-string flush makes one such decision per symbol taken (up to LOOKAHEAD).
// Reset clears the entry count, pending bytes, total and halt flag; the RAM is not cleared.
// A result waits in the output register while the next item is accepted; a second result
// holds in its emit state until the output register frees up.
`include "longest_match_symbol_sum_unit_assert.svh"

module longest_match_symbol_sum_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           func_i,
  input  logic [lmss_pkg::SYM_W-1:0]           entry_symbol_i,
  input  logic [lmss_pkg::REQ_W-1:0]           entry_length_i,
  input  logic signed [lmss_pkg::VAL_W-1:0]    entry_value_i,
  input  logic [lmss_pkg::BYTE_W-1:0]          text_byte_i,
  input  logic                                 last_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lmss_pkg::TOTAL_W-1:0]  total_o,
  output logic                                 stopped_early_o,
  output logic                                 table_full_o
);
  import lmss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPLY,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PEND_W-1:0]   pend_q, pend_d;
  logic [LEN_W-1:0]    fill_q, fill_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                halted_q, halted_d;
  logic                last_q, last_d;
  logic [CNT_W-1:0]    scan_idx_q, scan_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [TOTAL_W-1:0]  res_total_q, res_total_d;
  logic                res_stop_q, res_stop_d;
  logic                res_full_q, res_full_d;
  logic                out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;
  logic                out_stop_q, out_stop_d;
  logic                out_full_q, out_full_d;

  logic                in_acc;
  logic                issue;
  logic                ram_we;
  entry_t              wr_ent;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_ent;
  best_ctl_t           best_ctl;
  logic [LEN_W-1:0]    match_len;
  logic signed [VAL_W-1:0] best_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (state_q == S_SCAN) && (scan_idx_q < cnt_q);

  // Table writes happen only in idle, scans never overlap them
  assign ram_we     = in_acc && (func_i == FUNC_APPEND) && (cnt_q < CNT_W'(ENTRIES));
  assign wr_ent.sym = entry_symbol_i;
  assign wr_ent.len = eff_len(entry_symbol_i, entry_length_i);
  assign wr_ent.val = entry_value_i;

  lmss_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(wr_ent),
    .re_i   (issue),
    .raddr_i(scan_idx_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  assign best_ctl.clr  = (state_q == S_CHECK);
  assign best_ctl.eval = (state_q == S_SCAN) && rd_vld_q;

  lmss_best u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (best_ctl),
    .ent_i      (rd_ent),
    .pend_i     (pend_q),
    .fill_i     (fill_q),
    .match_len_o(match_len),
    .best_val_o (best_val)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    fill_d      = fill_q;
    total_d     = total_q;
    halted_d    = halted_q;
    last_d      = last_q;
    scan_idx_d  = scan_idx_q;
    rd_vld_d    = 1'b0;
    res_total_d = res_total_q;
    res_stop_d  = res_stop_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_total_d = out_total_q;
    out_stop_d  = out_stop_q;
    out_full_d  = out_full_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (func_i)
            FUNC_APPEND: begin
              if (cnt_q < CNT_W'(ENTRIES)) begin
                cnt_d = cnt_q + 1'b1;
              end else begin
                res_total_d = '0;
                res_stop_d  = 1'b0;
                res_full_d  = 1'b1;
                state_d     = S_EMIT;
              end
            end
            FUNC_PARSE: begin
              if (!halted_q) begin
                pend_d = pend_q | (PEND_W'(text_byte_i) << {fill_q, 3'b000});
                fill_d = fill_q + 1'b1;
              end
              last_d  = last_byte_i;
              state_d = S_CHECK;
            end
            FUNC_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (!halted_q && (fill_q != '0) && (last_q || (fill_q == LEN_W'(LOOKAHEAD)))) begin
          scan_idx_d = '0;
          state_d    = S_SCAN;
        end else if (last_q) begin
          // End of string: report and reset the per-string state
          res_total_d = total_q;
          res_stop_d  = halted_q;
          res_full_d  = 1'b0;
          total_d     = '0;
          pend_d      = '0;
          fill_d      = '0;
          halted_d    = 1'b0;
          state_d     = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // Read entry k while evaluating entry k-1
        rd_vld_d = issue;
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (match_len == '0) begin
          halted_d = 1'b1;
          pend_d   = '0;
          fill_d   = '0;
        end else begin
          total_d = total_q + {{(TOTAL_W-VAL_W){best_val[VAL_W-1]}}, best_val};
          pend_d  = pend_q >> {match_len, 3'b000};
          fill_d  = fill_q - match_len;
        end
        state_d = S_CHECK;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_total_d = res_total_q;
          out_stop_d  = res_stop_q;
          out_full_d  = res_full_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      halted_q    <= 1'b0;
      last_q      <= 1'b0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      res_total_q <= '0;
      res_stop_q  <= 1'b0;
      res_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
      out_stop_q  <= 1'b0;
      out_full_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      halted_q    <= halted_d;
      last_q      <= last_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_vld_d;
      res_total_q <= res_total_d;
      res_stop_q  <= res_stop_d;
      res_full_q  <= res_full_d;
      out_valid_q <= out_valid_d;
      out_total_q <= out_total_d;
      out_stop_q  <= out_stop_d;
      out_full_q  <= out_full_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign total_o         = out_total_q;
  assign stopped_early_o = out_stop_q;
  assign table_full_o    = out_full_q;

  // Checks
  `LMSS_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= LEN_W'(LOOKAHEAD), "pending fill overflow")
  `LMSS_ASSERT_NOW(a_halt_empty, halted_q, (fill_q == '0) && (pend_q == '0), "halted with bytes")
  `LMSS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(ENTRIES), "entry count overflow")
  `LMSS_ASSERT_NEXT(a_miss_halts, (state_q == S_APPLY) && (match_len == '0), halted_q, "miss")

endmodule
